@@ rtl/core/pidpv_pkg.sv @@
// Shared types and constants of the pose PID velocity controller.
package pidpv_pkg;

    // Fixed-point widths
    localparam int ERR_W   = 32;            // Q16.16 error
    localparam int INT_W   = 48;            // integral and derivative
    localparam int PER_W   = 24;            // saturated period, us
    localparam int DVD_W   = 58;            // signed dividend
    localparam int QUO_W   = 59;            // signed quotient
    localparam int PROD_W  = 66;            // shared multiplier product
    localparam int LOC_W   = 53;            // local (body) command
    localparam int MULA_W  = 34;
    localparam int MULB_W  = 32;

    // Iterative divider: 4 quotient bits per cycle over a 60-bit word
    localparam int DIV_W    = 60;
    localparam int DIV_STEP = 4;
    localparam int DIV_ITER = DIV_W / DIV_STEP;

    localparam logic [PER_W-1:0]         INT_DIVISOR = 24'd2000000;
    localparam logic signed [MULB_W-1:0] DER_SCALE   = 32'sd1000000;
    localparam logic signed [MULA_W-1:0] ONE_Q28     = 34'sd268435456;
    localparam logic signed [LOC_W-1:0]  LOC_CAP     = 53'sd268435456;
    localparam logic signed [ERR_W-1:0]  GOAL_CAP    = 32'sd13108;
    localparam logic [31:0]              GOAL_SQ_LIM = 32'd171798692;
    localparam logic signed [PROD_W-1:0] ONE_Q14     = 66'sd16384;

    // Term order inside one axis
    localparam logic [3:0] TERM_P = 4'd0;
    localparam logic [3:0] TERM_I = 4'd1;
    localparam logic [3:0] TERM_D = 4'd2;

    // Quaternion pair products
    localparam logic [3:0] QP_XX = 4'd0;
    localparam logic [3:0] QP_YY = 4'd1;
    localparam logic [3:0] QP_ZZ = 4'd2;
    localparam logic [3:0] QP_XY = 4'd3;
    localparam logic [3:0] QP_XZ = 4'd4;
    localparam logic [3:0] QP_YZ = 4'd5;
    localparam logic [3:0] QP_WX = 4'd6;
    localparam logic [3:0] QP_WY = 4'd7;
    localparam logic [3:0] QP_WZ = 4'd8;
    localparam int         QP_N  = 9;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_YAW = 2'd3;

    typedef enum logic [2:0] {
        REG_KP     = 3'd0,
        REG_KI     = 3'd1,
        REG_KD     = 3'd2,
        REG_GOAL_X = 3'd3,
        REG_GOAL_Y = 3'd4,
        REG_GOAL_Z = 3'd5,
        REG_GOAL_YAW = 3'd6,
        REG_ENABLE = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_GMUL,
        OP_GACC,
        OP_IMUL,
        OP_IDIV,
        OP_IUPD,
        OP_DMUL,
        OP_DDIV,
        OP_DUPD,
        OP_TLO,
        OP_TSET,
        OP_THI,
        OP_TADD,
        OP_LADD,
        OP_QMUL,
        OP_QST,
        OP_RMUL,
        OP_VACC,
        OP_VSET,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic [3:0] sel;
    } cmd_t;

    typedef struct packed {
        logic run;
        logic zero_p;
        logic div_busy;
    } status_t;

endpackage

@@ rtl/core/pidpv_div.sv @@
// Iterative signed-by-unsigned divider, truncating toward zero.
module pidpv_div import pidpv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic [PER_W-1:0]        divisor,
    output logic                    busy,
    output logic signed [QUO_W-1:0] quotient
);

    logic                    busy_reg;
    logic [3:0]              cnt_reg;
    logic [DIV_W-1:0]        dq_reg;
    logic [DIV_W-1:0]        dq_next;
    logic [PER_W-1:0]        rem_reg;
    logic [PER_W-1:0]        rem_next;
    logic [PER_W-1:0]        dsr_reg;
    logic                    neg_reg;
    logic signed [QUO_W-1:0] quo_reg;
    logic [DVD_W-1:0]        mag;
    logic [QUO_W-1:0]        q_mag;

    assign mag   = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
    assign q_mag = {1'b0, dq_reg[DVD_W-1:0]};

    // four restoring steps per cycle
    always_comb
    begin
        logic [PER_W:0]   t;
        logic [PER_W-1:0] r;
        logic [DIV_W-1:0] d;
        r = rem_reg;
        d = dq_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t = {r, d[DIV_W-1]};
            d = {d[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, dsr_reg})
            begin
                t    = t - {1'b0, dsr_reg};
                d[0] = 1'b1;
            end
            r = t[PER_W-1:0];
        end
        rem_next = r;
        dq_next  = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'(DIV_ITER))
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= {{(DIV_W-DVD_W){1'b0}}, mag};
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= dividend[DVD_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'(DIV_ITER))
                quo_reg <= neg_reg ? -$signed(q_mag) : $signed(q_mag);
            else
            begin
                dq_reg  <= dq_next;
                rem_reg <= rem_next;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/pidpv_dp.sv @@
// Datapath: registers, state, shared multiplier and divider of the controller.
module pidpv_dp import pidpv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             sts,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [15:0]  yaw_angle,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    input  logic [47:0]         stamp_us,
    output logic signed [15:0]  vel_x,
    output logic signed [15:0]  vel_y,
    output logic signed [15:0]  vel_z,
    output logic signed [15:0]  vel_yaw,
    output logic                command_valid,
    output logic                goal_reached,
    output logic                zero_period
);

    // configuration
    logic [63:0]        kp_reg, ki_reg, kd_reg;
    logic signed [31:0] goal_x_reg, goal_y_reg, goal_z_reg;
    logic signed [15:0] goal_yaw_reg;
    logic               enable_reg;

    // persistent state
    logic                    first_reg;
    logic [47:0]             last_stamp_reg;
    logic signed [ERR_W-1:0] prior_reg [4];
    logic signed [INT_W-1:0] integ_reg [4];

    // per-item registers
    logic signed [ERR_W-1:0]  err_reg [4];
    logic [PER_W-1:0]         period_reg;
    logic                     run_reg;
    logic                     zp_reg;
    logic signed [15:0]       qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [31:0]              gsq_reg;
    logic signed [PROD_W-1:0] tacc_reg;
    logic signed [LOC_W-1:0]  loc_reg [4];
    logic signed [INT_W-1:0]  d_reg;
    logic signed [31:0]       qp_reg [QP_N];
    logic signed [PROD_W-1:0] vacc_reg;
    logic signed [15:0]       velw_reg [3];

    // output item
    logic signed [15:0] vel_x_reg, vel_y_reg, vel_z_reg, vel_yaw_reg;
    logic               cv_reg, gr_reg, zp_out_reg;

    // combinational
    logic signed [ERR_W-1:0]  err_in [4];
    logic signed [32:0]       dx, dy, dz;
    logic signed [16:0]       dyaw;
    logic [47:0]              pdiff;
    logic [PER_W-1:0]         pcap;
    logic signed [ERR_W-1:0]  err_cur, prior_cur;
    logic signed [INT_W-1:0]  integ_cur;
    logic signed [32:0]       sum33, diff33;
    logic signed [INT_W-1:0]  val48;
    logic [15:0]              gain;
    logic signed [15:0]       qa, qb;
    logic signed [MULA_W-1:0] rsel;
    logic signed [LOC_W-1:0]  loc_sel;
    logic signed [29:0]       locsat;
    logic signed [MULA_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [INT_W:0]    integ_sum;
    logic signed [QUO_W-1:0]  div_q;
    logic                     div_busy;
    logic                     div_start;
    logic [PER_W-1:0]         div_divisor;
    logic                     goal_now;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        return v[31:0];
    endfunction

    function automatic logic signed [INT_W-1:0] sat48_q(input logic signed [QUO_W-1:0] v);
        if ((&v[QUO_W-1:INT_W-1]) || !(|v[QUO_W-1:INT_W-1]))
            return v[INT_W-1:0];
        return v[QUO_W-1] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    endfunction

    function automatic logic signed [INT_W-1:0] sat48_s(input logic signed [INT_W:0] v);
        if (v[INT_W] != v[INT_W-1])
            return v[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
        return v[INT_W-1:0];
    endfunction

    function automatic logic signed [15:0] sat_q14(input logic signed [PROD_W-1:0] v);
        if (v > ONE_Q14)
            return 16'sd16384;
        if (v < -ONE_Q14)
            return -16'sd16384;
        return v[15:0];
    endfunction

    function automatic logic near_goal(input logic signed [ERR_W-1:0] e);
        return (e < GOAL_CAP) && (e > -GOAL_CAP);
    endfunction

    // errors and period of the incoming item
    assign dx    = {goal_x_reg[31], goal_x_reg} - {pos_x[31], pos_x};
    assign dy    = {goal_y_reg[31], goal_y_reg} - {pos_y[31], pos_y};
    assign dz    = {goal_z_reg[31], goal_z_reg} - {pos_z[31], pos_z};
    assign dyaw  = {goal_yaw_reg[15], goal_yaw_reg} - {yaw_angle[15], yaw_angle};
    assign err_in[0] = sat32(dx);
    assign err_in[1] = sat32(dy);
    assign err_in[2] = sat32(dz);
    assign err_in[3] = {{12{dyaw[16]}}, dyaw, 3'b000};   // Q3.13 -> Q16.16
    assign pdiff = stamp_us - last_stamp_reg;
    assign pcap  = (|pdiff[47:PER_W]) ? {PER_W{1'b1}} : pdiff[PER_W-1:0];

    assign err_cur   = err_reg[cmd.axis];
    assign prior_cur = prior_reg[cmd.axis];
    assign integ_cur = integ_reg[cmd.axis];
    assign sum33     = {err_cur[31], err_cur} + {prior_cur[31], prior_cur};
    assign diff33    = {err_cur[31], err_cur} - {prior_cur[31], prior_cur};
    assign integ_sum = {integ_cur[INT_W-1], integ_cur} + div_q[INT_W:0];
    assign loc_sel   = loc_reg[cmd.sel[1:0]];

    // term operand and gain
    always_comb
    begin
        case (cmd.sel)
            TERM_P:  val48 = INT_W'(err_cur);
            TERM_I:  val48 = integ_cur;
            default: val48 = d_reg;
        endcase
        case (cmd.sel)
            TERM_P:  gain = kp_reg[{cmd.axis, 4'b0000} +: 16];
            TERM_I:  gain = ki_reg[{cmd.axis, 4'b0000} +: 16];
            default: gain = kd_reg[{cmd.axis, 4'b0000} +: 16];
        endcase
    end

    // quaternion pair
    always_comb
    begin
        case (cmd.sel)
            QP_XX:   begin qa = qx_reg; qb = qx_reg; end
            QP_YY:   begin qa = qy_reg; qb = qy_reg; end
            QP_ZZ:   begin qa = qz_reg; qb = qz_reg; end
            QP_XY:   begin qa = qx_reg; qb = qy_reg; end
            QP_XZ:   begin qa = qx_reg; qb = qz_reg; end
            QP_YZ:   begin qa = qy_reg; qb = qz_reg; end
            QP_WX:   begin qa = qw_reg; qb = qx_reg; end
            QP_WY:   begin qa = qw_reg; qb = qy_reg; end
            default: begin qa = qw_reg; qb = qz_reg; end
        endcase
    end

    // rotation entry r[k][i], k = sel, i = axis (Q2.28)
    always_comb
    begin
        logic signed [MULA_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        xx = MULA_W'(qp_reg[QP_XX]);
        yy = MULA_W'(qp_reg[QP_YY]);
        zz = MULA_W'(qp_reg[QP_ZZ]);
        xy = MULA_W'(qp_reg[QP_XY]);
        xz = MULA_W'(qp_reg[QP_XZ]);
        yz = MULA_W'(qp_reg[QP_YZ]);
        wx = MULA_W'(qp_reg[QP_WX]);
        wy = MULA_W'(qp_reg[QP_WY]);
        wz = MULA_W'(qp_reg[QP_WZ]);
        case ({cmd.sel[1:0], cmd.axis})
            4'h0:    rsel = ONE_Q28 - ((yy + zz) <<< 1);
            4'h1:    rsel = (xy - wz) <<< 1;
            4'h2:    rsel = (xz + wy) <<< 1;
            4'h4:    rsel = (xy + wz) <<< 1;
            4'h5:    rsel = ONE_Q28 - ((xx + zz) <<< 1);
            4'h6:    rsel = (yz - wx) <<< 1;
            4'h8:    rsel = (xz - wy) <<< 1;
            4'h9:    rsel = (yz + wx) <<< 1;
            4'hA:    rsel = ONE_Q28 - ((xx + yy) <<< 1);
            default: rsel = '0;
        endcase
    end

    always_comb
    begin
        if (loc_sel > LOC_CAP)
            locsat = 30'sd268435456;
        else if (loc_sel < -LOC_CAP)
            locsat = -30'sd268435456;
        else
            locsat = loc_sel[29:0];
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_GMUL:
            begin
                mul_a = MULA_W'(err_cur);
                mul_b = err_cur;
            end
            OP_IMUL:
            begin
                mul_a = MULA_W'(sum33);
                mul_b = {8'd0, period_reg};
            end
            OP_DMUL:
            begin
                mul_a = MULA_W'(diff33);
                mul_b = DER_SCALE;
            end
            OP_TLO:
            begin
                mul_a = {18'd0, gain};
                mul_b = {8'd0, val48[23:0]};
            end
            OP_THI:
            begin
                mul_a = {18'd0, gain};
                mul_b = {{8{val48[INT_W-1]}}, val48[INT_W-1:24]};
            end
            OP_QMUL:
            begin
                mul_a = MULA_W'(qa);
                mul_b = MULB_W'(qb);
            end
            OP_RMUL:
            begin
                mul_a = rsel;
                mul_b = MULB_W'(locsat);
            end
            default: ;
        endcase
    end

    assign prod_next   = mul_a * mul_b;
    assign div_start   = (cmd.op == OP_IDIV) || (cmd.op == OP_DDIV);
    assign div_divisor = (cmd.op == OP_IDIV) ? INT_DIVISOR : period_reg;

    pidpv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[DVD_W-1:0]),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // squared distance below 0.04 m^2 <=> 25 * sq < 2^32
    assign goal_now = near_goal(err_reg[0]) && near_goal(err_reg[1]) &&
                      near_goal(err_reg[2]) && (gsq_reg < GOAL_SQ_LIM);

    // configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg         <= 64'd8796227241984;
            ki_reg         <= 64'd352192692306;
            kd_reg         <= 64'd5278595351757;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            goal_z_reg     <= 32'sd65536;
            goal_yaw_reg   <= '0;
            enable_reg     <= 1'b0;
            first_reg      <= 1'b1;
            last_stamp_reg <= '0;
            run_reg        <= 1'b0;
            zp_reg         <= 1'b0;
            prior_reg      <= '{default: '0};
            integ_reg      <= '{default: '0};
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_KP:       kp_reg       <= cfg_data;
                    REG_KI:       ki_reg       <= cfg_data;
                    REG_KD:       kd_reg       <= cfg_data;
                    REG_GOAL_X:   goal_x_reg   <= cfg_data[31:0];
                    REG_GOAL_Y:   goal_y_reg   <= cfg_data[31:0];
                    REG_GOAL_Z:   goal_z_reg   <= cfg_data[31:0];
                    REG_GOAL_YAW: goal_yaw_reg <= cfg_data[15:0];
                    REG_ENABLE:   enable_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_CAPTURE:
                begin
                    first_reg      <= 1'b0;
                    last_stamp_reg <= stamp_us;
                    run_reg        <= enable_reg && !first_reg;
                    zp_reg         <= (pcap == '0);
                end
                OP_IUPD: integ_reg[cmd.axis] <= sat48_s(integ_sum);
                OP_DUPD: prior_reg[cmd.axis] <= err_cur;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (cmd.op)
            OP_CAPTURE:
            begin
                err_reg    <= err_in;
                period_reg <= pcap;
                qw_reg     <= quat_w;
                qx_reg     <= quat_x;
                qy_reg     <= quat_y;
                qz_reg     <= quat_z;
                gsq_reg    <= '0;
                loc_reg    <= '{default: '0};
            end
            OP_GACC: gsq_reg <= gsq_reg + prod_reg[31:0];
            OP_DUPD: d_reg   <= zp_reg ? '0 : sat48_q(div_q);
            OP_TSET: tacc_reg <= prod_reg;
            OP_TADD: tacc_reg <= tacc_reg + (prod_reg <<< 24);
            OP_LADD: loc_reg[cmd.axis] <= loc_reg[cmd.axis] + LOC_W'(tacc_reg >>> 14);
            OP_QST:  qp_reg[cmd.sel] <= prod_reg[31:0];
            OP_VACC: vacc_reg <= ((cmd.sel == '0) ? '0 : vacc_reg) + prod_reg;
            OP_VSET: velw_reg[cmd.axis] <= sat_q14(vacc_reg >>> 28);
            OP_PUBLISH:
            begin
                vel_x_reg   <= run_reg ? velw_reg[0] : '0;
                vel_y_reg   <= run_reg ? velw_reg[1] : '0;
                vel_z_reg   <= run_reg ? velw_reg[2] : '0;
                vel_yaw_reg <= run_reg ? sat_q14(PROD_W'(loc_reg[AXIS_YAW])) : '0;
                cv_reg      <= run_reg;
                gr_reg      <= goal_now;
                zp_out_reg  <= run_reg && zp_reg;
            end
            default: ;
        endcase
    end

    assign sts.run      = run_reg;
    assign sts.zero_p   = zp_reg;
    assign sts.div_busy = div_busy;

    assign vel_x         = vel_x_reg;
    assign vel_y         = vel_y_reg;
    assign vel_z         = vel_z_reg;
    assign vel_yaw       = vel_yaw_reg;
    assign command_valid = cv_reg;
    assign goal_reached  = gr_reg;
    assign zero_period   = zp_out_reg;

endmodule

@@ rtl/core/pidpv_ctrl.sv @@
// Sequencer that steps the datapath through one pose item.
module pidpv_ctrl import pidpv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    typedef enum logic [21:0] {
        S_IDLE  = 22'd1 << 0,
        S_GMUL  = 22'd1 << 1,
        S_GACC  = 22'd1 << 2,
        S_IMUL  = 22'd1 << 3,
        S_IDIV  = 22'd1 << 4,
        S_IWAIT = 22'd1 << 5,
        S_IUPD  = 22'd1 << 6,
        S_DMUL  = 22'd1 << 7,
        S_DDIV  = 22'd1 << 8,
        S_DWAIT = 22'd1 << 9,
        S_DUPD  = 22'd1 << 10,
        S_TLO   = 22'd1 << 11,
        S_TSET  = 22'd1 << 12,
        S_THI   = 22'd1 << 13,
        S_TADD  = 22'd1 << 14,
        S_LADD  = 22'd1 << 15,
        S_QMUL  = 22'd1 << 16,
        S_QST   = 22'd1 << 17,
        S_RMUL  = 22'd1 << 18,
        S_VACC  = 22'd1 << 19,
        S_VSET  = 22'd1 << 20,
        S_DONE  = 22'd1 << 21
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [3:0] sel_reg, sel_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NOP;
        cmd.axis   = axis_reg;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    axis_next  = AXIS_X;
                    sel_next   = '0;
                    state_next = S_GMUL;
                end
            end
            S_GMUL:
            begin
                cmd.op     = OP_GMUL;
                state_next = S_GACC;
            end
            S_GACC:
            begin
                cmd.op = OP_GACC;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next  = AXIS_X;
                    state_next = sts.run ? S_IMUL : S_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_GMUL;
                end
            end
            S_IMUL:
            begin
                cmd.op     = OP_IMUL;
                state_next = S_IDIV;
            end
            S_IDIV:
            begin
                cmd.op     = OP_IDIV;
                state_next = S_IWAIT;
            end
            S_IWAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_IUPD;
            end
            S_IUPD:
            begin
                cmd.op     = OP_IUPD;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.op     = OP_DMUL;
                state_next = S_DDIV;
            end
            S_DDIV:
            begin
                // zero period: derivative is forced to zero, no divide
                if (sts.zero_p)
                    state_next = S_DUPD;
                else
                begin
                    cmd.op     = OP_DDIV;
                    state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_DUPD;
            end
            S_DUPD:
            begin
                cmd.op     = OP_DUPD;
                sel_next   = TERM_P;
                state_next = S_TLO;
            end
            S_TLO:
            begin
                cmd.op     = OP_TLO;
                state_next = S_TSET;
            end
            S_TSET:
            begin
                cmd.op     = OP_TSET;
                state_next = S_THI;
            end
            S_THI:
            begin
                cmd.op     = OP_THI;
                state_next = S_TADD;
            end
            S_TADD:
            begin
                cmd.op     = OP_TADD;
                state_next = S_LADD;
            end
            S_LADD:
            begin
                cmd.op = OP_LADD;
                if (sel_reg == TERM_D)
                begin
                    sel_next = '0;
                    if (axis_reg == AXIS_YAW)
                    begin
                        axis_next  = AXIS_X;
                        state_next = S_QMUL;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_IMUL;
                    end
                end
                else
                begin
                    sel_next   = sel_reg + 4'd1;
                    state_next = S_TLO;
                end
            end
            S_QMUL:
            begin
                cmd.op     = OP_QMUL;
                state_next = S_QST;
            end
            S_QST:
            begin
                cmd.op = OP_QST;
                if (sel_reg == QP_WZ)
                begin
                    sel_next   = '0;
                    axis_next  = AXIS_X;
                    state_next = S_RMUL;
                end
                else
                begin
                    sel_next   = sel_reg + 4'd1;
                    state_next = S_QMUL;
                end
            end
            S_RMUL:
            begin
                cmd.op     = OP_RMUL;
                state_next = S_VACC;
            end
            S_VACC:
            begin
                cmd.op = OP_VACC;
                if (sel_reg == 4'd2)
                    state_next = S_VSET;
                else
                begin
                    sel_next   = sel_reg + 4'd1;
                    state_next = S_RMUL;
                end
            end
            S_VSET:
            begin
                cmd.op   = OP_VSET;
                sel_next = '0;
                if (axis_reg == AXIS_Z)
                    state_next = S_DONE;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_RMUL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.op == OP_PUBLISH)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // a publish never overwrites an item the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_PUBLISH |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    // the derivative divide is never waited on for a zero period
    a_no_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DWAIT |-> !sts.zero_p)
        else $error("divide by zero period");

    // the integral and derivative updates only read a finished quotient
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IUPD || state_reg == S_DUPD) |-> !sts.div_busy)
        else $error("quotient used while divider busy");

    // results appear only after a publish
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == OP_PUBLISH))
        else $error("output valid without publish");

endmodule

@@ rtl/core/pid_position_velocity_controller.sv @@
// Top level of the pose-driven PID velocity controller.
//
// Input channel (in_valid/in_ready): one pose item per handshake with
// position, yaw, quaternion and a microsecond stamp. Output channel
// (out_valid/out_ready): one item of four Q1.14 velocity commands plus
// command_valid, goal_reached and zero_period for every input item.
// Config port: cfg_we writes cfg_data into register cfg_index at once.
// The first sample, or a sample with control disabled, only runs the goal
// test before its output; a controlled sample also runs, per axis, an
// integral and a derivative divide (4 quotient bits per cycle; the
// derivative divide is skipped when the period is zero) and a chain of
// multiplies on one shared 34x32 multiplier; one item is in work at a time.
// The input is taken again as soon as the result is parked in the output
// register; if the receiver stalls, the next result waits in its final
// step until the output register frees up.
// Reset sets configuration and controller state to their defaults: first
// sample pending, zero integrals and prior errors, control disabled.
module pid_position_velocity_controller import pidpv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic [47:0]        stamp_us,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] vel_x,
    output logic signed [15:0] vel_y,
    output logic signed [15:0] vel_z,
    output logic signed [15:0] vel_yaw,
    output logic               command_valid,
    output logic               goal_reached,
    output logic               zero_period
);

    cmd_t    cmd;
    status_t sts;

    // sequencer
    pidpv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic, state and output register
    pidpv_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .yaw_angle     (yaw_angle),
        .quat_w        (quat_w),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .stamp_us      (stamp_us),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .vel_z         (vel_z),
        .vel_yaw       (vel_yaw),
        .command_valid (command_valid),
        .goal_reached  (goal_reached),
        .zero_period   (zero_period)
    );

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the pose PID velocity controller: random and directed pose items, scoreboard check.
`timescale 1ns / 1ps

module tb;
    import pidpv_pkg::*;

    // One pose sample as it crosses the input channel
    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] yaw;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic [47:0]        stamp;
    } pose_t;

    // One velocity command item as it leaves the output channel
    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] vyaw;
        logic               cmd_ok;
        logic               at_goal;
        logic               zp;
    } cmd_item_t;

    localparam longint S32_HI  = 64'sd2147483647;
    localparam longint S32_LO  = -64'sd2147483648;
    localparam longint S48_HI  = 64'sd140737488355327;
    localparam longint S48_LO  = -64'sd140737488355328;
    localparam longint Q14_ONE = 64'sd16384;
    localparam longint Q28_ONE = 64'sd268435456;
    localparam longint NEAR    = 64'sd13108;
    localparam int     STALL_LIMIT = 5000;
    localparam int     DRAIN_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] vel_x, vel_y, vel_z, vel_yaw;
    logic command_valid, goal_reached, zero_period;

    pose_t cur_pose;

    pid_position_velocity_controller uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(cur_pose.pos_x), .pos_y(cur_pose.pos_y), .pos_z(cur_pose.pos_z),
        .yaw_angle(cur_pose.yaw),
        .quat_w(cur_pose.qw), .quat_x(cur_pose.qx), .quat_y(cur_pose.qy),
        .quat_z(cur_pose.qz), .stamp_us(cur_pose.stamp),
        .out_valid(out_valid), .out_ready(out_ready),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .vel_yaw(vel_yaw),
        .command_valid(command_valid), .goal_reached(goal_reached),
        .zero_period(zero_period)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Register copies; only touched while the block is idle
    logic [63:0]        kp_m, ki_m, kd_m;
    logic signed [31:0] gx_m, gy_m, gz_m;
    logic signed [15:0] gyaw_m;
    logic               en_m;

    // Controller state copy
    logic        first_m;
    logic [47:0] last_stamp_m;
    longint      prior_err_m[4];
    longint      integ_m[4];

    pose_t     pending_poses[$];
    cmd_item_t expected_cmds[$];
    int        mismatches;
    bit        quiet;           // no idling on either side
    int        in_gap, out_gap;
    int        stall_cnt;
    logic [47:0] gen_stamp;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Expected command item for one accepted pose; advances the state copy
    function automatic cmd_item_t control_step(pose_t p);
        cmd_item_t r;
        longint err[4];
        longint loc[4];
        longint vel[4];
        longint rm[3][3];
        longint inc, d, pr, sq, acc, w, x, y, z;
        logic [47:0] per;
        vel = '{0, 0, 0, 0};
        r.cmd_ok = 1'b0;
        r.zp = 1'b0;
        r.at_goal = 1'b0;
        err[0] = clip(longint'(gx_m) - longint'(p.pos_x), S32_LO, S32_HI);
        err[1] = clip(longint'(gy_m) - longint'(p.pos_y), S32_LO, S32_HI);
        err[2] = clip(longint'(gz_m) - longint'(p.pos_z), S32_LO, S32_HI);
        err[3] = (longint'(gyaw_m) - longint'(p.yaw)) * 8;
        // goal test only inside a box that keeps the squares small
        if (err[0] < NEAR && err[0] > -NEAR && err[1] < NEAR && err[1] > -NEAR &&
            err[2] < NEAR && err[2] > -NEAR)
        begin
            sq = err[0] * err[0] + err[1] * err[1] + err[2] * err[2];
            r.at_goal = (25 * sq < 64'sd4294967296);
        end
        if (first_m)
        begin
            // first sample only records its stamp
            first_m = 1'b0;
            last_stamp_m = p.stamp;
        end
        else
        begin
            per = p.stamp - last_stamp_m;   // wraps at 48 bits
            last_stamp_m = p.stamp;
            if (per > 48'hFFFFFF)
                per = 48'hFFFFFF;
            if (en_m)
            begin
                pr = longint'(per);
                r.cmd_ok = 1'b1;
                r.zp = (per == 0);
                for (int a = 0; a < 4; a++)
                begin
                    inc = (err[a] + prior_err_m[a]) * pr / 64'sd2000000;
                    integ_m[a] = clip(integ_m[a] + inc, S48_LO, S48_HI);
                    d = 0;
                    if (per != 0)
                        d = clip((err[a] - prior_err_m[a]) * 64'sd1000000 / pr, S48_LO, S48_HI);
                    loc[a] = ((err[a] * longint'(kp_m[16*a +: 16])) >>> 14)
                           + ((integ_m[a] * longint'(ki_m[16*a +: 16])) >>> 14)
                           + ((d * longint'(kd_m[16*a +: 16])) >>> 14);
                    prior_err_m[a] = err[a];
                end
                w = longint'(p.qw);
                x = longint'(p.qx);
                y = longint'(p.qy);
                z = longint'(p.qz);
                rm[0][0] = Q28_ONE - 2 * (y * y + z * z);
                rm[0][1] = 2 * (x * y - w * z);
                rm[0][2] = 2 * (x * z + w * y);
                rm[1][0] = 2 * (x * y + w * z);
                rm[1][1] = Q28_ONE - 2 * (x * x + z * z);
                rm[1][2] = 2 * (y * z - w * x);
                rm[2][0] = 2 * (x * z - w * y);
                rm[2][1] = 2 * (y * z + w * x);
                rm[2][2] = Q28_ONE - 2 * (x * x + y * y);
                for (int k = 0; k < 3; k++)
                    loc[k] = clip(loc[k], -Q28_ONE, Q28_ONE);
                // body command goes through the transposed rotation
                for (int i = 0; i < 3; i++)
                begin
                    acc = rm[0][i] * loc[0] + rm[1][i] * loc[1] + rm[2][i] * loc[2];
                    vel[i] = clip(acc >>> 28, -Q14_ONE, Q14_ONE);
                end
                vel[3] = clip(loc[3], -Q14_ONE, Q14_ONE);
            end
        end
        r.vx = vel[0][15:0];
        r.vy = vel[1][15:0];
        r.vz = vel[2][15:0];
        r.vyaw = vel[3][15:0];
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Driver: feeds the pose queue, holding each item until taken
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic vld_n;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            vld_n = in_valid;
            if (in_valid && in_ready)
            begin
                expected_cmds.push_back(control_step(cur_pose));
                vld_n = 1'b0;
            end
            if (!vld_n)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending_poses.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(0, 12);     // idle gap of random length
                    else
                    begin
                        cur_pose <= pending_poses.pop_front();
                        vld_n = 1'b1;
                    end
                end
            end
            in_valid <= vld_n;
        end
    end

    // Monitor: random receiver stalls, checks each command item in order
    always @(posedge clk or negedge rst_n)
    begin : monitor
        cmd_item_t want;
        logic rdy_n;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_cmds.size() == 0)
                    report("unexpected item", 1, 0);
                else
                begin
                    want = expected_cmds.pop_front();
                    if (vel_x !== want.vx)
                        report("vel_x", vel_x, want.vx);
                    if (vel_y !== want.vy)
                        report("vel_y", vel_y, want.vy);
                    if (vel_z !== want.vz)
                        report("vel_z", vel_z, want.vz);
                    if (vel_yaw !== want.vyaw)
                        report("vel_yaw", vel_yaw, want.vyaw);
                    if (command_valid !== want.cmd_ok)
                        report("command_valid", command_valid, want.cmd_ok);
                    if (goal_reached !== want.at_goal)
                        report("goal_reached", goal_reached, want.at_goal);
                    if (zero_period !== want.zp)
                        report("zero_period", zero_period, want.zp);
                end
            end
            rdy_n = 1'b1;
            if (out_gap > 0)
            begin
                out_gap--;
                rdy_n = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_gap = $urandom_range(0, 12);
                rdy_n = 1'b0;
            end
            out_ready <= rdy_n;
        end
    end

    // Watchdog: too long with no item moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic cfg_write(cfg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_KP:       kp_m = val;
            REG_KI:       ki_m = val;
            REG_KD:       kd_m = val;
            REG_GOAL_X:   gx_m = val[31:0];
            REG_GOAL_Y:   gy_m = val[31:0];
            REG_GOAL_Z:   gz_m = val[31:0];
            REG_GOAL_YAW: gyaw_m = val[15:0];
            default:      en_m = val[0];
        endcase
    endtask

    task automatic set_all(logic [63:0] kp, logic [63:0] ki, logic [63:0] kd,
                           logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                           logic [15:0] gyaw, logic en);
        cfg_write(REG_KP, kp);
        cfg_write(REG_KI, ki);
        cfg_write(REG_KD, kd);
        cfg_write(REG_GOAL_X, {32'd0, gx});
        cfg_write(REG_GOAL_Y, {32'd0, gy});
        cfg_write(REG_GOAL_Z, {32'd0, gz});
        cfg_write(REG_GOAL_YAW, {48'd0, gyaw});
        cfg_write(REG_ENABLE, {63'd0, en});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued item is through and the block has settled
    task automatic drain();
        while (pending_poses.size() > 0 || in_valid || expected_cmds.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_gains();
        logic [63:0] g;
        for (int a = 0; a < 4; a++)
            g[16*a +: 16] = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 12000);
        return g;
    endfunction

    function automatic logic signed [15:0] rand_quat();
        if ($urandom_range(0, 15) == 0)
            return $urandom;                // outside the unit range too
        return $urandom_range(0, 32768) - 16384;
    endfunction

    function automatic logic signed [31:0] near_goal(logic signed [31:0] g, bit close);
        if (close)
            return g + $urandom_range(0, 20000) - 10000;
        return g + $urandom_range(0, 2000000) - 1000000;
    endfunction

    // Mostly a plausible trajectory; some items are pure noise
    task automatic add_random(int n);
        pose_t p;
        bit close;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                p.pos_x = $urandom;
                p.pos_y = $urandom;
                p.pos_z = $urandom;
                p.yaw = $urandom;
                p.qw = $urandom;
                p.qx = $urandom;
                p.qy = $urandom;
                p.qz = $urandom;
                p.stamp = {$urandom, $urandom};
            end
            else
            begin
                close = ($urandom_range(0, 2) == 0);
                p.pos_x = near_goal(gx_m, close);
                p.pos_y = near_goal(gy_m, close);
                p.pos_z = near_goal(gz_m, close);
                p.yaw = gyaw_m + $urandom_range(0, 8000) - 4000;
                p.qw = rand_quat();
                p.qx = rand_quat();
                p.qy = rand_quat();
                p.qz = rand_quat();
                p.stamp = ($urandom_range(0, 19) == 0) ? gen_stamp
                                                       : gen_stamp + $urandom_range(1, 50000);
            end
            gen_stamp = p.stamp;
            pending_poses.push_back(p);
        end
    endtask

    task automatic add_pose(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [15:0] yaw,
                            logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                            logic [15:0] qz, logic [47:0] stamp);
        pose_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        p.yaw = yaw;
        p.qw = qw;
        p.qx = qx;
        p.qy = qy;
        p.qz = qz;
        p.stamp = stamp;
        gen_stamp = stamp;
        pending_poses.push_back(p);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KP;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        quiet = 1'b0;
        mismatches = 0;
        stall_cnt = 0;
        gen_stamp = '0;
        cur_pose = '{default: '0};
        first_m = 1'b1;
        last_stamp_m = '0;
        for (int a = 0; a < 4; a++)
        begin
            prior_err_m[a] = 0;
            integ_m[a] = 0;
        end
        kp_m = 64'd8796227241984;
        ki_m = 64'd352192692306;
        kd_m = 64'd5278595351757;
        gx_m = 0;
        gy_m = 0;
        gz_m = 32'sd65536;
        gyaw_m = 0;
        en_m = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Control off: first sample only stores its stamp, then zero commands
        set_all(64'd8796227241984, 64'd352192692306, 64'd5278595351757,
                0, 0, 32'd65536, 0, 1'b0);
        add_pose(0, 0, 32'd65536, 0, 16'd16384, 0, 0, 0, 48'd1000);
        add_pose(32'd1000, 0, 0, 16'h1234, 16'd16384, 0, 0, 0, 48'd21000);
        drain();

        // Control on, reset gains: special cases in turn
        set_all(64'd8796227241984, 64'd352192692306, 64'd5278595351757,
                0, 0, 32'd65536, 0, 1'b1);
        add_pose(32'd6553, 32'hFFFF_E000, 32'd60000, 16'd100, 16'd16384, 0, 0, 0, 48'd41000);
        add_pose(0, 0, 32'd65536, 0, 16'd16384, 0, 0, 0, 48'd41000);        // zero period
        add_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h7FFF,
                 16'hC000, 16'd16384, 16'hC000, 16'd16384, 48'd30000);     // stamp backward
        add_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000,
                 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 48'h0000_4000_0000); // huge gap
        add_pose(0, 0, 32'd65536, 0, 0, 16'd16384, 0, 0, 48'hFFFF_FFFF_FFFF);
        add_pose(32'd1, 32'd2, 32'd65539, 16'd1, 0, 0, 16'd16384, 0, 48'd5);  // wraps past zero
        add_pose(32'd20000, 0, 32'd65536, 16'hFFFF, 0, 0, 0, 16'd16384, 48'd1005);
        add_pose(32'd13107, 0, 32'd65536, 0, 16'd11585, 16'd11585, 0, 0, 48'd2005);
        add_pose(32'd13108, 0, 32'd65536, 0, 16'd11585, 0, 16'd11585, 0, 48'd3005);
        add_pose(0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 48'd3006);
        drain();

        // Largest gains and goals at their top
        set_all('1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 1'b1);
        add_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000,
                 16'd16384, 0, 0, 0, 48'd10000);
        add_pose(32'h8000_0000, 0, 32'h7FFF_FFFF, 16'h8000, 16'd16384, 0, 0, 0, 48'd10001);
        add_random(48);
        drain();

        // Zero gains and goals at their bottom
        set_all('0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 1'b1);
        add_random(50);
        drain();

        // Random settings; the last phase runs without idling
        for (int ph = 0; ph < 5; ph++)
        begin
            set_all(rand_gains(), rand_gains(), rand_gains(),
                    $urandom_range(0, 400000) - 200000, $urandom_range(0, 400000) - 200000,
                    $urandom_range(0, 400000) - 200000, $urandom,
                    $urandom_range(0, 4) != 0);
            quiet = (ph == 4);
            add_random(65);
            drain();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/pidpv_pkg.sv
rtl/core/pidpv_div.sv
rtl/core/pidpv_dp.sv
rtl/core/pidpv_ctrl.sv
rtl/core/pid_position_velocity_controller.sv
tb/sv/tb.sv
